>>> src/spcm_pkg.sv
`default_nettype none
package spcm_pkg;

    localparam int MAG_WIDTH      = 24;
    localparam int LOG_TABLE_BITS = 8;

    // Width of the scaled magnitude, a Q16.32 product.
    localparam int PROD_WIDTH = 48;
    // Width of the exponent that the leading one gives.
    localparam int EXP_WIDTH  = 6;
    // log2 results in Q16: exponent above sixteen fraction bits.
    localparam int LOG_WIDTH  = EXP_WIDTH + 16;
    // Mantissa in Q1.30.
    localparam int MANT_WIDTH = 31;

    localparam logic [PROD_WIDTH-1:0] EPS_Q32      = 48'd4;
    localparam logic [21:0]           DB_SLOPE_Q24 = 22'd1442984;
    localparam logic [16:0]           ONE_Q16      = 17'd65536;

    localparam logic [0:0] REG_PEAK_RECIP = 1'b0;
    localparam logic [0:0] REG_GAMMA      = 1'b1;

    localparam logic [23:0] PEAK_RECIP_RESET = 24'd65536;
    localparam logic [14:0] GAMMA_RESET      = 15'd10650;

    localparam logic [16:0] STOP_POS [0:5] = '{
        17'd0, 17'd13107, 17'd26214, 17'd40632, 17'd52429, 17'd65536
    };
    localparam logic [7:0] STOP_RGB [0:5][0:2] = '{
        '{8'd0,   8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd60},
        '{8'd0,   8'd20,  8'd210},
        '{8'd10,  8'd130, 8'd255},
        '{8'd20,  8'd230, 8'd255},
        '{8'd180, 8'd255, 8'd255}
    };
    // Segment widths and floor(2^24 / width) for the reciprocal divide.
    localparam logic [13:0] SPAN  [0:4] = '{
        14'd13107, 14'd13107, 14'd14418, 14'd11797, 14'd13107
    };
    localparam logic [10:0] RECIP [0:4] = '{
        11'd1280, 11'd1280, 11'd1163, 11'd1422, 11'd1280
    };

    typedef struct packed {
        logic                  valid;
        logic [PROD_WIDTH-1:0] x;
    } log_in_t;

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic [LOG_WIDTH-1:0] value;
    } log_out_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bit_w > v) begin
                bit_w = bit_w >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_w != 64'd0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-j) in Q30, by repeated square roots from one half.
    function automatic logic [29:0] gamma_factor(input int j);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 1; i <= 16; i++) begin
            if (i <= j) begin
                c = isqrt64(c << 30);
            end
        end
        return c[29:0];
    endfunction

endpackage
`default_nettype wire

>>> src/spcm_log2.sv
`default_nettype none
module spcm_log2 (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire spcm_pkg::log_in_t  log_in,
    output spcm_pkg::log_out_t      log_out
);
    import spcm_pkg::*;

    localparam int LTB = LOG_TABLE_BITS;

    logic                  norm_valid_reg, norm_valid_next;
    logic                  norm_zero_reg, norm_zero_next;
    logic [EXP_WIDTH-1:0]  norm_exp_reg, norm_exp_next;
    logic [PROD_WIDTH-1:0] norm_x_reg;

    logic                  sq_valid_reg [0:LTB];
    logic                  sq_zero_reg  [0:LTB];
    logic [EXP_WIDTH-1:0]  sq_exp_reg   [0:LTB];
    logic [MANT_WIDTH-1:0] sq_m_reg     [0:LTB];
    logic [LTB-1:0]        sq_f_reg     [0:LTB];
    logic [MANT_WIDTH-1:0] sq_m_next    [0:LTB];
    logic [LTB-1:0]        sq_f_next    [0:LTB];

    always_comb begin
        norm_valid_next = log_in.valid;
        norm_zero_next  = (log_in.x == '0);
        norm_exp_next   = '0;
        for (int i = 0; i < PROD_WIDTH; i++) begin
            if (log_in.x[i]) begin
                norm_exp_next = EXP_WIDTH'(i);
            end
        end
    end

    // Bring the leading one to bit 30.
    always_comb begin
        if (norm_exp_reg >= EXP_WIDTH'(30)) begin
            sq_m_next[0] = MANT_WIDTH'(norm_x_reg >> (norm_exp_reg - EXP_WIDTH'(30)));
        end else begin
            sq_m_next[0] = MANT_WIDTH'(norm_x_reg << (EXP_WIDTH'(30) - norm_exp_reg));
        end
        sq_f_next[0] = '0;
    end

    for (genvar k = 1; k <= LTB; k++) begin : g_square
        logic [2*MANT_WIDTH-1:0] sq;
        logic [31:0]             sq_shr;
        assign sq     = sq_m_reg[k-1] * sq_m_reg[k-1];
        assign sq_shr = sq[61:30];
        assign sq_m_next[k] = sq_shr[31] ? sq_shr[31:1] : sq_shr[30:0];
        assign sq_f_next[k] = {sq_f_reg[k-1][LTB-2:0], sq_shr[31]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_valid_reg <= 1'b0;
            for (int i = 0; i <= LTB; i++) begin
                sq_valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            norm_valid_reg  <= norm_valid_next;
            sq_valid_reg[0] <= norm_valid_reg;
            for (int i = 1; i <= LTB; i++) begin
                sq_valid_reg[i] <= sq_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            norm_zero_reg  <= norm_zero_next;
            norm_exp_reg   <= norm_exp_next;
            norm_x_reg     <= log_in.x;
            sq_zero_reg[0] <= norm_zero_reg;
            sq_exp_reg[0]  <= norm_exp_reg;
            for (int i = 1; i <= LTB; i++) begin
                sq_zero_reg[i] <= sq_zero_reg[i-1];
                sq_exp_reg[i]  <= sq_exp_reg[i-1];
            end
            for (int i = 0; i <= LTB; i++) begin
                sq_m_reg[i] <= sq_m_next[i];
                sq_f_reg[i] <= sq_f_next[i];
            end
        end
    end

    assign log_out.valid = sq_valid_reg[LTB];
    assign log_out.zero  = sq_zero_reg[LTB];
    assign log_out.value = sq_zero_reg[LTB] ? '0
                         : {sq_exp_reg[LTB], sq_f_reg[LTB], {(16-LTB){1'b0}}};

endmodule
`default_nettype wire

>>> src/spectrogram_pixel_colour_map.sv
`default_nettype none
// Spectrogram pixel colour map.
// One spectral magnitude enters on the s_ stream and one RGB pixel leaves on
// the m_ stream for it, in the same order. A transfer happens on a rising edge
// of aclk where tvalid and tready of that channel are both high.
// Throughput is one pixel per cycle: every stage holds at most one sample and
// the whole pipeline moves together whenever the output register is empty or
// its pixel is being taken.
// Latency is 45 register stages. It is set by the two log2 units (ten stages
// each, eight of them mantissa squarings), the sixteen-step gamma factor chain
// and the four-stage colour ramp with its reciprocal divide.
// When the receiver holds m_tready low with a pixel waiting, every stage
// stalls and s_tready falls, so nothing is lost or repeated.
// The cfg_ channel writes peak_reciprocal (index 0) or gamma (index 1); it is
// always ready and other indexes are ignored. Write it only while idle.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// registers with 1.0 and about 0.65.
module spectrogram_pixel_colour_map (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] magnitude
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata
);
    import spcm_pkg::*;

    logic        adv;

    logic [23:0] peak_recip_reg;
    logic [14:0] gamma_reg;

    // The pipeline moves as a whole; a stalled output freezes every stage.
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_recip_reg <= PEAK_RECIP_RESET;
            gamma_reg      <= GAMMA_RESET;
        end else if (cfg_valid && cfg_addr[7:1] == 7'd0) begin
            unique case (cfg_addr[0])
                REG_PEAK_RECIP: peak_recip_reg <= cfg_wdata;
                REG_GAMMA:      gamma_reg      <= cfg_wdata[14:0];
                default:        ;
            endcase
        end
    end

    // Stage: scale by the peak reciprocal and add the epsilon.
    logic                  sc_valid_reg;
    logic [PROD_WIDTH-1:0] sc_p_reg, sc_p_next;
    assign sc_p_next = PROD_WIDTH'(s_tdata[MAG_WIDTH-1:0]) * PROD_WIDTH'(peak_recip_reg)
                     + EPS_Q32;

    log_in_t  log1_in, log2_in;
    log_out_t log1_out, log2_out;

    assign log1_in.valid = sc_valid_reg;
    assign log1_in.x     = sc_p_reg;

    spcm_log2 u_log_level (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .log_in  (log1_in),
        .log_out (log1_out)
    );

    // Stage: decibel slope, then offset and clamp to an intensity in 0..1.
    logic               in_valid_reg, it_valid_reg;
    logic signed [22:0] in_d;
    logic signed [44:0] in_prod_reg, in_prod_next;
    logic signed [45:0] it_acc;
    logic [16:0]        it_t_reg, it_t_next;

    assign in_d         = $signed({1'b0, log1_out.value}) - 23'sd2097152;
    assign in_prod_next = 45'(in_d) * 45'($signed({1'b0, DB_SLOPE_Q24}));
    assign it_acc       = (46'sd1 <<< 40) + 46'(in_prod_reg);

    always_comb begin
        if (it_acc <= 46'sd0) begin
            it_t_next = '0;
        end else if (it_acc[45:24] > 22'(ONE_Q16)) begin
            it_t_next = ONE_Q16;
        end else begin
            it_t_next = it_acc[40:24];
        end
    end

    assign log2_in.valid = it_valid_reg;
    assign log2_in.x     = PROD_WIDTH'(it_t_reg);

    spcm_log2 u_log_intensity (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .log_in  (log2_in),
        .log_out (log2_out)
    );

    // Stage: exponent y = gamma * -log2(I); then one factor per fraction bit.
    logic [20:0] ex_nl;
    logic [35:0] ex_y;
    assign ex_nl = 21'd1048576 - log2_out.value[20:0];
    assign ex_y  = 36'(gamma_reg) * 36'(ex_nl);

    logic        ch_valid_reg [0:16];
    logic        ch_gz_reg    [0:16];
    logic        ch_tz_reg    [0:16];
    logic [5:0]  ch_ip_reg    [0:16];
    logic [15:0] ch_fr_reg    [0:16];
    logic [30:0] ch_r_reg     [0:16];
    logic [30:0] ch_r_next    [0:16];

    assign ch_r_next[0] = 31'd1 << 30;

    for (genvar j = 1; j <= 16; j++) begin : g_factor
        localparam logic [29:0] FAC = gamma_factor(j);
        logic [60:0] prod;
        assign prod         = ch_r_reg[j-1] * FAC;
        assign ch_r_next[j] = ch_fr_reg[j-1][16-j] ? prod[60:30] : ch_r_reg[j-1];
    end

    // Stage: final shift and the zero gamma and zero intensity cases.
    logic        gv_valid_reg;
    logic [16:0] gv_g_reg, gv_g_next;
    logic [6:0]  gv_sh;
    assign gv_sh = 7'd14 + 7'(ch_ip_reg[16]);

    always_comb begin
        if (ch_gz_reg[16]) begin
            gv_g_next = ONE_Q16;
        end else if (ch_tz_reg[16]) begin
            gv_g_next = '0;
        end else begin
            gv_g_next = 17'(ch_r_reg[16] >> gv_sh);
        end
    end

    // Colour ramp: segment, products, reciprocal divide, correction.
    logic        r1_valid_reg, r2_valid_reg, r3_valid_reg;
    logic [2:0]  r1_lo_reg, r1_lo_next, r2_lo_reg, r3_lo_reg;
    logic [15:0] r1_off_reg, r1_off_next;
    logic [7:0]  r1_a_reg [0:2], r2_a_reg [0:2], r3_a_reg [0:2];
    logic [7:0]  r1_d_reg [0:2], r1_d_next [0:2];
    logic [23:0] r2_n_reg [0:2], r2_n_next [0:2], r3_n_reg [0:2];
    logic [7:0]  r3_q_reg [0:2], r3_q_next [0:2];
    logic [7:0]  out_ch_next [0:2];
    logic [23:0] m_data_reg;
    logic        m_valid_reg;

    always_comb begin
        r1_lo_next = 3'd4;
        for (int i = 4; i >= 0; i--) begin
            if (gv_g_reg <= STOP_POS[i+1]) begin
                r1_lo_next = 3'(i);
            end
        end
        r1_off_next = 16'(gv_g_reg - STOP_POS[r1_lo_next]);
        for (int c = 0; c < 3; c++) begin
            r1_d_next[c] = STOP_RGB[r1_lo_next + 3'd1][c] - STOP_RGB[r1_lo_next][c];
        end
    end

    always_comb begin
        logic [34:0] qp;
        logic [23:0] rem;
        logic [21:0] qs;
        for (int c = 0; c < 3; c++) begin
            r2_n_next[c] = 24'(r1_d_reg[c]) * 24'(r1_off_reg);
            qp           = 35'(r2_n_reg[c]) * 35'(RECIP[r2_lo_reg]);
            r3_q_next[c] = qp[31:24];
            qs           = 22'(r3_q_reg[c]) * 22'(SPAN[r3_lo_reg]);
            rem          = r3_n_reg[c] - 24'(qs);
            if (rem >= 24'(SPAN[r3_lo_reg])) begin
                out_ch_next[c] = r3_a_reg[c] + r3_q_reg[c] + 8'd1;
            end else begin
                out_ch_next[c] = r3_a_reg[c] + r3_q_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg <= 1'b0;
            in_valid_reg <= 1'b0;
            it_valid_reg <= 1'b0;
            for (int i = 0; i <= 16; i++) begin
                ch_valid_reg[i] <= 1'b0;
            end
            gv_valid_reg <= 1'b0;
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            sc_valid_reg    <= s_tvalid;
            in_valid_reg    <= log1_out.valid;
            it_valid_reg    <= in_valid_reg;
            ch_valid_reg[0] <= log2_out.valid;
            for (int i = 1; i <= 16; i++) begin
                ch_valid_reg[i] <= ch_valid_reg[i-1];
            end
            gv_valid_reg <= ch_valid_reg[16];
            r1_valid_reg <= gv_valid_reg;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            m_valid_reg  <= r3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sc_p_reg     <= sc_p_next;
            in_prod_reg  <= in_prod_next;
            it_t_reg     <= it_t_next;
            ch_gz_reg[0] <= (gamma_reg == 15'd0);
            ch_tz_reg[0] <= log2_out.zero;
            ch_ip_reg[0] <= ex_y[35:30];
            ch_fr_reg[0] <= ex_y[29:14];
            for (int i = 1; i <= 16; i++) begin
                ch_gz_reg[i] <= ch_gz_reg[i-1];
                ch_tz_reg[i] <= ch_tz_reg[i-1];
                ch_ip_reg[i] <= ch_ip_reg[i-1];
                ch_fr_reg[i] <= ch_fr_reg[i-1];
            end
            for (int i = 0; i <= 16; i++) begin
                ch_r_reg[i] <= ch_r_next[i];
            end
            gv_g_reg   <= gv_g_next;
            r1_lo_reg  <= r1_lo_next;
            r1_off_reg <= r1_off_next;
            r2_lo_reg  <= r1_lo_reg;
            r3_lo_reg  <= r2_lo_reg;
            for (int c = 0; c < 3; c++) begin
                r1_a_reg[c] <= STOP_RGB[r1_lo_next][c];
                r1_d_reg[c] <= r1_d_next[c];
                r2_a_reg[c] <= r1_a_reg[c];
                r2_n_reg[c] <= r2_n_next[c];
                r3_a_reg[c] <= r2_a_reg[c];
                r3_n_reg[c] <= r2_n_reg[c];
                r3_q_reg[c] <= r3_q_next[c];
            end
            m_data_reg <= {out_ch_next[2], out_ch_next[1], out_ch_next[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire
